@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // sorted insert of the incoming entry
    logic rem;  // pop the front, everything moves one toward the front
  } cell_op_t;

endpackage

@@ rtl/core/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// The result is registered: it is captured at the edge that accepts the request.
// Throughput: one request per cycle while the result side does not stall; every
// cell updates in parallel, so a sorted insert or a front removal is done by all cells at once.
// Reset (rst_ni, async, active low) empties the queue and drops any pending result;
// entry storage is not cleared and is only read at occupied positions.
module stable_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PRIO_BITS    = 16,
  parameter int unsigned PAYLOAD_BITS = 32,
  localparam int unsigned CntW        = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic [PRIO_BITS-1:0]    key_priority_i,
  input  logic [PAYLOAD_BITS-1:0] entry_payload_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    front_valid_o,
  output logic [PRIO_BITS-1:0]    front_priority_o,
  output logic [PAYLOAD_BITS-1:0] front_payload_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         occupancy_o
);

  // Request transfer happens whenever the result register is free or is
  // being emptied in the same cycle.
  logic in_xfer;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  logic [CntW-1:0] count_q, count_d;
  logic            empty, full;
  logic            is_ins, is_rem, is_peek;
  cell_op_t        op;

  assign empty   = (count_q == '0);
  assign full    = (count_q == CntW'(DEPTH));
  assign is_ins  = (kind_i == KIND_INSERT);
  assign is_rem  = (kind_i == KIND_REMOVE);
  assign is_peek = (kind_i == KIND_PEEK);

  assign op.ins = in_xfer && is_ins && !full;
  assign op.rem = in_xfer && is_rem && !empty;

  // ---------------------------------------------------------------------------
  // Cell chain: slot 0 is the front. Each cell compares its entry against the
  // incoming key; the ge flags form a prefix, and the first cell outside it
  // takes the new entry while the rest shift one place back.
  // ---------------------------------------------------------------------------
  logic                    ge_w      [DEPTH];
  logic [PRIO_BITS-1:0]    prio_w    [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    left_ge;
    logic [PRIO_BITS-1:0]    left_prio,  right_prio;
    logic [PAYLOAD_BITS-1:0] left_pay,   right_pay;

    if (g == 0) begin : g_head
      assign left_ge   = 1'b1;
      assign left_prio = key_priority_i;
      assign left_pay  = entry_payload_i;
    end else begin : g_body
      assign left_ge   = ge_w[g-1];
      assign left_prio = prio_w[g-1];
      assign left_pay  = payload_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      // last slot becomes unoccupied on a removal; its content is then unused
      assign right_prio = prio_w[g];
      assign right_pay  = payload_w[g];
    end else begin : g_mid
      assign right_prio = prio_w[g+1];
      assign right_pay  = payload_w[g+1];
    end

    spq_cell #(
      .PRIO_BITS   (PRIO_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .op_i           (op),
      .occupied_i     (CntW'(g) < count_q),
      .key_i          (key_priority_i),
      .data_i         (entry_payload_i),
      .left_ge_i      (left_ge),
      .left_prio_i    (left_prio),
      .left_payload_i (left_pay),
      .right_prio_i   (right_prio),
      .right_payload_i(right_pay),
      .ge_o           (ge_w[g]),
      .prio_o         (prio_w[g]),
      .payload_o      (payload_w[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                    front_hit;
  logic [1:0]              status_d;

  assign front_hit = (is_rem || is_peek) && !empty;

  always_comb begin
    status_d = ST_DONE;
    if (is_ins && full) begin
      status_d = ST_FULL;
    end else if ((is_rem || is_peek) && empty) begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      front_valid_o    <= front_hit;
      front_priority_o <= front_hit ? prio_w[0]    : '0;
      front_payload_o  <= front_hit ? payload_w[0] : '0;
      status_o         <= status_d;
      occupancy_o      <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count exceeds depth");

  a_full_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_ins && full) |=> (status_o == ST_FULL && count_q == $past(count_q)))
    else $error("insert into full queue not rejected");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (is_rem || is_peek) && empty) |=> (!front_valid_o && status_o == ST_EMPTY))
    else $error("empty remove/peek reported an entry");

  a_occ_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_xfer) |-> (occupancy_o == count_q))
    else $error("reported occupancy differs from held count");

endmodule

@@ rtl/core/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
  parameter int unsigned PRIO_BITS    = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk_i,
  input  cell_op_t                op_i,
  input  logic                    occupied_i,
  input  logic [PRIO_BITS-1:0]    key_i,
  input  logic [PAYLOAD_BITS-1:0] data_i,
  input  logic                    left_ge_i,
  input  logic [PRIO_BITS-1:0]    left_prio_i,
  input  logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  logic [PRIO_BITS-1:0]    right_prio_i,
  input  logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic                    ge_o,
  output logic [PRIO_BITS-1:0]    prio_o,
  output logic [PAYLOAD_BITS-1:0] payload_o
);

  logic [PRIO_BITS-1:0]    prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;

  // Held entry stays ahead of the new one (equal keys keep arrival order).
  assign ge_o = occupied_i && (prio_q >= key_i);

  always_comb begin
    prio_d    = prio_q;
    payload_d = payload_q;
    if (op_i.ins && !ge_o) begin
      if (left_ge_i) begin
        // first cell past the run of higher/equal keys takes the new entry
        prio_d    = key_i;
        payload_d = data_i;
      end else begin
        prio_d    = left_prio_i;
        payload_d = left_payload_i;
      end
    end else if (op_i.rem) begin
      prio_d    = right_prio_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int unsigned Q_DEPTH      = 16;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned PAY_W        = 32;
  localparam int unsigned OCC_W        = 5;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;  // no-op code, must be ignored
  localparam int          MAX_REPORTS  = 10;
  localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int          DRAIN_LIMIT  = 20000;
  localparam int          PHASE_ITEMS  = 380;

  // one result transfer as seen on the output ports
  typedef struct packed {
    logic              front_valid;
    logic [PRIO_W-1:0] front_priority;
    logic [PAY_W-1:0]  front_payload;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
  } spq_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i          = KIND_INSERT;
  logic [PRIO_W-1:0] key_priority_i  = '0;
  logic [PAY_W-1:0]  entry_payload_i = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic              front_valid_o;
  logic [PRIO_W-1:0] front_priority_o;
  logic [PAY_W-1:0]  front_payload_o;
  logic [1:0]        status_o;
  logic [OCC_W-1:0]  occupancy_o;

  stable_priority_queue #(
    .DEPTH       (Q_DEPTH),
    .PRIO_BITS   (PRIO_W),
    .PAYLOAD_BITS(PAY_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .key_priority_i  (key_priority_i),
    .entry_payload_i (entry_payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .front_valid_o   (front_valid_o),
    .front_priority_o(front_priority_o),
    .front_payload_o (front_payload_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue: slot 0 is the front, sorted by descending
  // priority, equal priorities kept in arrival order.
  // ---------------------------------------------------------------------------
  logic [PRIO_W-1:0] shadow_prio [Q_DEPTH];
  logic [PAY_W-1:0]  shadow_pay  [Q_DEPTH];
  int                shadow_held = 0;

  spq_result_t       pending_results[$];

  // run statistics, for the closing summary only
  int n_requests = 0;
  int n_inserts  = 0;
  int n_rejected = 0;
  int n_on_empty = 0;
  int n_unused   = 0;
  int n_results  = 0;

  int mismatch_count = 0;

  // traffic shaping knobs
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req_id     = 0;  // bumped by a test to start a receiver hold-off

  // Advance the shadow queue by one request and return what the block owes.
  function automatic spq_result_t predict_result(input logic [1:0]        kind,
                                                 input logic [PRIO_W-1:0] prio,
                                                 input logic [PAY_W-1:0]  pay);
    spq_result_t r;
    int          pos;
    r = '0;
    r.status = ST_DONE;
    n_requests++;
    case (kind)
      KIND_INSERT: begin
        n_inserts++;
        if (shadow_held == Q_DEPTH) begin
          // full: rejected, queue untouched
          r.status = ST_FULL;
          n_rejected++;
        end else begin
          // new entry goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < shadow_held && shadow_prio[pos] >= prio) pos++;
          for (int i = shadow_held; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_pay[i]  = shadow_pay[i-1];
          end
          shadow_prio[pos] = prio;
          shadow_pay[pos]  = pay;
          shadow_held++;
        end
      end
      KIND_REMOVE, KIND_PEEK: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
          n_on_empty++;
        end else begin
          r.front_valid    = 1'b1;
          r.front_priority = shadow_prio[0];
          r.front_payload  = shadow_pay[0];
          if (kind == KIND_REMOVE) begin
            for (int i = 1; i < shadow_held; i++) begin
              shadow_prio[i-1] = shadow_prio[i];
              shadow_pay[i-1]  = shadow_pay[i];
            end
            shadow_held--;
          end
        end
      end
      default: n_unused++;  // unused code: no change, plain done status
    endcase
    r.occupancy = OCC_W'(shadow_held);
    return r;
  endfunction

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Request transfers are predicted first so that the order of
  // the two lookups does not matter even if a result leaves with its request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    spq_result_t got;
    spq_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        pending_results.push_back(predict_result(kind_i, key_priority_i, entry_payload_i));
      if (out_valid_o && out_ready_i) begin
        got = '{front_valid_o, front_priority_o, front_payload_o, status_o, occupancy_o};
        n_results++;
        if (pending_results.size() == 0) begin
          note_error($sformatf(
                       "result with nothing expected: fv=%0b prio=%h pay=%h st=%0d occ=%0d",
                       got.front_valid, got.front_priority, got.front_payload,
                       got.status, got.occupancy));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_error($sformatf({"exp fv=%0b prio=%h pay=%h st=%0d occ=%0d | ",
                                  "got fv=%0b prio=%h pay=%h st=%0d occ=%0d"},
                                 want.front_valid, want.front_priority, want.front_payload,
                                 want.status, want.occupancy,
                                 got.front_valid, got.front_priority, got.front_payload,
                                 got.status, got.occupancy));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request. The hold-off is
  // counted here so the sender keeps pushing while the result side is blocked.
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_req_id != hold_seen) begin
      hold_seen = hold_req_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge of the transfer, or
  // after a random idle gap. Valid stays high when no gap follows so that the
  // next call only updates the request fields.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0]        kind,
                              input logic [PRIO_W-1:0] prio,
                              input logic [PAY_W-1:0]  pay);
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    key_priority_i  <= prio;
    entry_payload_i <= pay;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Random request; ins_pct steers occupancy so that both full and empty
  // conditions keep coming up. Small priorities dominate to force ties.
  task automatic send_random(input int ins_pct);
    logic [1:0]        kind;
    logic [PRIO_W-1:0] prio;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 3)                       kind = KIND_UNUSED;
    else if (pick < 3 + ins_pct * 97 / 100) kind = KIND_INSERT;
    else if ($urandom_range(2) != 0)    kind = KIND_REMOVE;
    else                                kind = KIND_PEEK;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: prio = PRIO_W'($urandom_range(7));
      5, 6:          prio = PRIO_W'($urandom());
      7:             prio = '0;
      8:             prio = '1;
      default:       prio = PRIO_W'(16'hfff8 + $urandom_range(7));
    endcase
    send_request(kind, prio, PAY_W'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // remove / peek / unused code on an empty queue
  task automatic test_empty_queue();
    send_request(KIND_REMOVE, '1, '1);
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_UNUSED, 16'h1234, 32'hdead_beef);
  endtask

  // priority extremes and FIFO order among equal priorities
  task automatic test_ties_and_extremes();
    send_request(KIND_INSERT, 16'h0000, 32'h0000_0000);
    send_request(KIND_INSERT, 16'hffff, 32'hffff_ffff);
    send_request(KIND_INSERT, 16'hffff, 32'h0000_0001);
    send_request(KIND_INSERT, 16'h0000, 32'ha5a5_a5a5);
    send_request(KIND_INSERT, 16'h8000, 32'h5a5a_5a5a);
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_REMOVE, '0, '0);
    send_request(KIND_REMOVE, '0, '0);
  endtask

  // top up to full, then an insert that must bounce, then a peek at full
  task automatic test_full_queue();
    for (int i = 0; i < Q_DEPTH - 3; i++)
      send_request(KIND_INSERT, PRIO_W'($urandom_range(3)), PAY_W'($urandom()));
    send_request(KIND_INSERT, 16'hffff, 32'hffff_ffff);
    send_request(KIND_PEEK, '0, '0);
  endtask

  // block the result side for a long stretch while requests keep coming
  task automatic test_result_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req_id    <= hold_req_id + 1;
    for (int i = 0; i < 40; i++) send_random(60);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    int mix [5];
    mix = '{85, 15, 50, 95, 30};
    sender_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random(mix[(i / 40) % 5]);
  endtask

  initial begin : main
    int waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_ties_and_extremes();
    test_full_queue();
    test_random_phase(0, 0);
    test_result_backpressure();
    test_random_phase(64, 0);
    test_random_phase(0, 64);
    test_random_phase(20, 20);

    // stop offering, let the last results drain; wait for an edge first so the
    // final request transfer is already in the expected queue
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));

    $display({"run covered %0d requests (%0d inserts, %0d rejected on full, ",
              "%0d on empty, %0d unused)"},
             n_requests, n_inserts, n_rejected, n_on_empty, n_unused);
    $display("checked %0d results, %0d mismatches", n_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[stable_priority_queue] OK");
    end else begin
      $display("[stable_priority_queue] ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout waiting for the queue");
    $display("[stable_priority_queue] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue.sv
verif/tb_top.sv
